// ===== rtl/core/cartridge_bank_mapper_with_irq_unit_assert.svh =====
// Assertion macros for the cartridge bank mapper.
// Used by modules that carry concurrent checks; needs clk and rst_n in scope.
`ifndef CARTRIDGE_BANK_MAPPER_WITH_IRQ_UNIT_ASSERT_SVH
`define CARTRIDGE_BANK_MAPPER_WITH_IRQ_UNIT_ASSERT_SVH

// same-cycle implication
`define CBM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CBM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/cbm_pkg.sv =====
// Package for the cartridge bank mapper: widths, codes, command/status structs.
// No dependencies.
package cbm_pkg;
  localparam int FRAC_BITS = 8;
  localparam int CNT_W     = 16 + FRAC_BITS;
  localparam int PAGE_W    = 11;
  localparam int PRG_W     = 9;
  localparam int CHR_W     = 11;
  localparam int STEP_W    = 16;
  localparam int NRES      = 12;
  localparam int IDX_W     = 4;

  localparam logic [2:0] KIND_START = 3'd0;
  localparam logic [2:0] KIND_WRITE = 3'd1;
  localparam logic [2:0] KIND_EXPW  = 3'd2;
  localparam logic [2:0] KIND_EXPR  = 3'd3;
  localparam logic [2:0] KIND_TICK  = 3'd4;

  localparam logic [2:0] EV_NONE = 3'd0;
  localparam logic [2:0] EV_PRG  = 3'd1;
  localparam logic [2:0] EV_CHR  = 3'd2;
  localparam logic [2:0] EV_MIR  = 3'd3;
  localparam logic [2:0] EV_READ = 3'd4;
  localparam logic [2:0] EV_IRQ  = 3'd5;

  localparam logic [1:0] CFG_PRG_PAGES = 2'd0;
  localparam logic [1:0] CFG_CHR_PAGES = 2'd1;
  localparam logic [1:0] CFG_STEP      = 2'd2;

  localparam logic [1:0] MOD_NONE = 2'd0;
  localparam logic [1:0] MOD_PRG  = 2'd1;
  localparam logic [1:0] MOD_CHR  = 2'd2;

  localparam logic [15:0] A_BANK0  = 16'h8000;
  localparam logic [15:0] A_BANK1  = 16'hB000;
  localparam logic [15:0] A_BANK2  = 16'hB0FF;
  localparam logic [15:0] A_BANK3  = 16'hB1FF;
  localparam logic [15:0] A_MODE   = 16'h8100;
  localparam logic [15:0] A_IRQ_LO = 16'h8200;
  localparam logic [15:0] A_IRQ_HI = 16'h8201;
  localparam logic [15:0] A_PRG0   = 16'h8300;
  localparam logic [15:0] A_PRG2   = 16'h8302;
  localparam logic [15:0] A_CHR0   = 16'h8310;
  localparam logic [15:0] A_CHR7   = 16'h8317;
  localparam logic [15:0] A_PRG_X  = 16'h8318;
  localparam logic [15:0] A_EXP_LO = 16'h5101;
  localparam logic [15:0] A_EXP_HI = 16'h5103;
  localparam logic [15:0] A_EXP_M  = 16'h5100;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DECODE = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_MOD    = 5'b01000,
    ST_OUT    = 5'b10000
  } state_t;

  typedef struct packed {
    logic latch;
    logic decode;
    logic next_idx;
    logic mod_start;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic cur_valid;
    logic none_left;
    logic need_mod;
    logic mod_busy;
  } stat_t;

  function automatic logic [2:0] pair_slot(input logic [2:0] a);
    logic [2:0] s;
    unique case (a)
      3'd0:    s = 3'd0;
      3'd1:    s = 3'd2;
      3'd2, 3'd4, 3'd6: s = 3'd4;
      default: s = 3'd6;
    endcase
    return s;
  endfunction
endpackage

// ===== rtl/core/cbm_mod.sv =====
// Restoring remainder unit, one dividend bit per cycle.
// Depends on cbm_pkg.
module cbm_mod (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [cbm_pkg::PAGE_W-1:0] dividend,
  input  logic [cbm_pkg::PAGE_W-1:0] divisor,
  output logic                      busy,
  output logic [cbm_pkg::PAGE_W-1:0] rem
);
  import cbm_pkg::*;
  localparam int CW = $clog2(PAGE_W + 1);

  logic              busy_r, busy_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [PAGE_W-1:0] dvd_r, dvd_nxt, div_r, div_nxt, rem_r, rem_nxt;
  logic [PAGE_W:0]   trial;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, dvd_r[PAGE_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(PAGE_W);
      dvd_nxt  = dividend;
      div_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (trial >= {1'b0, div_r}) rem_nxt = PAGE_W'(trial - {1'b0, div_r});
      else                        rem_nxt = PAGE_W'(trial);
      dvd_nxt  = dvd_r << 1;
      cnt_nxt  = cnt_r - CW'(1);
      busy_nxt = (cnt_r != CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
  end

  assign busy = busy_r;
  assign rem  = rem_r;
endmodule

// ===== rtl/core/cbm_dp.sv =====
// Mapper datapath: registers, result list generation, output register.
// Depends on cbm_pkg and cbm_mod.
module cbm_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cbm_pkg::cmd_t             cmd,
  output cbm_pkg::stat_t            st,
  input  logic [2:0]                in_kind,
  input  logic [15:0]               in_address,
  input  logic [7:0]                in_data,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [15:0]               cfg_wdata,
  output logic [2:0]                o_event,
  output logic [2:0]                o_slot,
  output logic [cbm_pkg::PAGE_W-1:0] o_page,
  output logic [7:0]                o_value,
  output logic                      o_last
);
  import cbm_pkg::*;

  logic [PRG_W-1:0]  prg_pages_r;
  logic [CHR_W-1:0]  chr_pages_r;
  logic [STEP_W-1:0] step_r;
  logic [2:0]  kind_r;
  logic [15:0] a_r;
  logic [7:0]  d_r;
  logic [7:0]  bank_r, bank_nxt, mode_r, mode_nxt, exp_r, exp_nxt;
  logic [9:0]  chr_base_r, chr_base_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic        en_r, en_nxt;
  logic [NRES-1:0]  mask_r, mask_c;
  logic [IDX_W-1:0] idx_r;
  logic [15:0] integ;
  logic        pnz, cnz, hit_irq;
  logic        is_bank, is_pair, is_single;
  logic [9:0]  x;
  logic [7:0]  e, y;
  logic [PRG_W-1:0] pm1, pm2;
  logic [2:0]  g_ev, g_slot;
  logic [PAGE_W-1:0] g_page;
  logic [7:0]  g_val;
  logic [1:0]  g_mod;
  logic        mod_busy;
  logic [PAGE_W-1:0] mod_rem;
  logic [PAGE_W-1:0] mod_div;

  assign pnz     = (prg_pages_r != '0);
  assign cnz     = (chr_pages_r != '0);
  assign integ   = 16'(cnt_r >> FRAC_BITS);
  assign hit_irq = en_r && (cnt_r <= CNT_W'(step_r));
  assign is_bank = (a_r == A_BANK0) || (a_r == A_BANK1) || (a_r == A_BANK2)
                || (a_r == A_BANK3);
  assign is_single = (mode_r[5:4] == 2'b11);
  assign is_pair   = (mode_r[5:4] == 2'b01) || (mode_r[5:4] == 2'b10);
  assign x   = chr_base_r ^ {2'b00, d_r};
  assign e   = {2'b00, d_r[5:4], 4'hF};
  assign y   = {2'b00, bank_r[5:4], 4'h0} | d_r;
  assign pm1 = (prg_pages_r >= PRG_W'(1)) ? prg_pages_r - PRG_W'(1) : '0;
  assign pm2 = (prg_pages_r >= PRG_W'(2)) ? prg_pages_r - PRG_W'(2) : '0;

  // state updates and result mask
  always_comb begin
    bank_nxt     = bank_r;
    mode_nxt     = mode_r;
    exp_nxt      = exp_r;
    chr_base_nxt = chr_base_r;
    cnt_nxt      = cnt_r;
    en_nxt       = en_r;
    mask_c       = '0;
    unique case (kind_r)
      KIND_START: begin
        bank_nxt     = '0;
        exp_nxt      = '0;
        chr_base_nxt = '0;
        cnt_nxt      = '0;
        en_nxt       = 1'b0;
        mode_nxt     = (prg_pages_r >= PRG_W'(32)) ? 8'h30 : 8'h00;
        mask_c       = {{8{cnz}}, {4{pnz}}};
      end
      KIND_WRITE: begin
        if (is_bank) begin
          bank_nxt     = d_r;
          chr_base_nxt = {d_r[5:4], 8'h00};
          mask_c[3:0]  = {4{pnz}};
        end else if (a_r == A_MODE) begin
          if (chr_pages_r <= CHR_W'(256)) mode_nxt = d_r;
          mask_c[0] = 1'b1;
        end else if (a_r == A_IRQ_LO) begin
          cnt_nxt = CNT_W'({integ[15:8], d_r}) << FRAC_BITS;
        end else if (a_r == A_IRQ_HI) begin
          cnt_nxt = CNT_W'({d_r, integ[7:0]}) << FRAC_BITS;
          en_nxt  = (d_r != 8'h00);
        end else if (a_r >= A_PRG0 && a_r <= A_PRG2) begin
          mask_c[0] = pnz;
        end else if (a_r >= A_CHR0 && a_r <= A_CHR7) begin
          if (is_single)    mask_c[0]   = cnz;
          else if (is_pair) mask_c[1:0] = {2{cnz}};
        end else if (a_r == A_PRG_X) begin
          mask_c[1:0] = {2{pnz}};
        end
      end
      KIND_EXPW: begin
        if (a_r >= A_EXP_LO && a_r <= A_EXP_HI) exp_nxt = d_r;
      end
      KIND_EXPR: mask_c[0] = 1'b1;
      KIND_TICK: begin
        if (hit_irq) begin
          en_nxt    = 1'b0;
          mask_c[0] = 1'b1;
        end else if (en_r) begin
          cnt_nxt = cnt_r - CNT_W'(step_r);
        end
      end
      default: ;
    endcase
  end

  // result entry at idx_r
  always_comb begin
    g_ev   = EV_NONE;
    g_slot = '0;
    g_page = '0;
    g_val  = '0;
    g_mod  = MOD_NONE;
    unique case (kind_r)
      KIND_START: begin
        if (idx_r < IDX_W'(4)) begin
          g_ev   = EV_PRG;
          g_mod  = MOD_PRG;
          g_slot = 3'(idx_r);
          unique case (idx_r[1:0])
            2'd0: g_page = '0;
            2'd1: g_page = PAGE_W'(1);
            2'd2: g_page = (prg_pages_r >= PRG_W'(32)) ? PAGE_W'(30) : PAGE_W'(pm2);
            default: g_page = (prg_pages_r >= PRG_W'(32)) ? PAGE_W'(31) : PAGE_W'(pm1);
          endcase
        end else begin
          g_ev   = EV_CHR;
          g_mod  = MOD_CHR;
          g_slot = 3'(idx_r - IDX_W'(4));
          g_page = PAGE_W'(idx_r - IDX_W'(4));
        end
      end
      KIND_WRITE: begin
        if (is_bank) begin
          g_ev   = EV_PRG;
          g_mod  = MOD_PRG;
          g_slot = 3'(idx_r);
          g_page = idx_r[1] ? PAGE_W'({e, idx_r[0]}) : PAGE_W'({d_r, idx_r[0]});
        end else if (a_r == A_MODE) begin
          g_ev  = EV_MIR;
          g_val = {6'h00, d_r[1:0]};
        end else if (a_r >= A_CHR0 && a_r <= A_CHR7) begin
          g_ev  = EV_CHR;
          g_mod = MOD_CHR;
          if (is_single) begin
            g_slot = a_r[2:0];
            g_page = PAGE_W'(x);
          end else begin
            g_slot = pair_slot(a_r[2:0]) | {2'b00, idx_r[0]};
            g_page = {x, idx_r[0]};
          end
        end else if (a_r == A_PRG_X) begin
          g_ev   = EV_PRG;
          g_mod  = MOD_PRG;
          g_slot = {2'b00, idx_r[0]};
          g_page = PAGE_W'({y, idx_r[0]});
        end else begin
          g_ev   = EV_PRG;
          g_mod  = MOD_PRG;
          g_slot = {1'b0, a_r[1:0]};
          g_page = PAGE_W'(d_r);
        end
      end
      KIND_EXPR: begin
        g_ev  = EV_READ;
        g_val = ((a_r & A_EXP_M) == A_EXP_M) ? exp_r : a_r[15:8];
      end
      default: g_ev = EV_IRQ;
    endcase
  end

  assign mod_div = (g_mod == MOD_CHR) ? chr_pages_r : PAGE_W'(prg_pages_r);

  cbm_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.mod_start),
    .dividend (g_page),
    .divisor  (mod_div),
    .busy     (mod_busy),
    .rem      (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_pages_r <= PRG_W'(16);
      chr_pages_r <= CHR_W'(256);
      step_r      <= STEP_W'(29104);
      bank_r      <= '0;
      mode_r      <= '0;
      exp_r       <= '0;
      chr_base_r  <= '0;
      cnt_r       <= '0;
      en_r        <= 1'b0;
      mask_r      <= '0;
      idx_r       <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PRG_PAGES: prg_pages_r <= cfg_wdata[PRG_W-1:0];
          CFG_CHR_PAGES: chr_pages_r <= cfg_wdata[CHR_W-1:0];
          CFG_STEP:      step_r      <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.decode) begin
        bank_r     <= bank_nxt;
        mode_r     <= mode_nxt;
        exp_r      <= exp_nxt;
        chr_base_r <= chr_base_nxt;
        cnt_r      <= cnt_nxt;
        en_r       <= en_nxt;
        mask_r     <= mask_c;
        idx_r      <= '0;
      end else if (cmd.next_idx) begin
        mask_r <= mask_r >> 1;
        idx_r  <= idx_r + IDX_W'(1);
      end
    end
    if (cmd.latch) begin
      kind_r <= in_kind;
      a_r    <= in_address;
      d_r    <= in_data;
    end
    if (cmd.load_out) begin
      o_event <= g_ev;
      o_slot  <= g_slot;
      o_page  <= (g_mod == MOD_NONE) ? '0 : mod_rem;
      o_value <= g_val;
      o_last  <= (mask_r[NRES-1:1] == '0);
    end
  end

  assign st.cur_valid = mask_r[0];
  assign st.none_left = (mask_r == '0);
  assign st.need_mod  = (g_mod != MOD_NONE);
  assign st.mod_busy  = mod_busy;
endmodule

// ===== rtl/core/cbm_ctrl.sv =====
// Mapper controller: accepts an item, walks its result list, hands results out.
// Depends on cbm_pkg and the assertion macro header.
`include "cartridge_bank_mapper_with_irq_unit_assert.svh"
module cbm_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  input  logic           out_last,
  input  cbm_pkg::stat_t st,
  output cbm_pkg::cmd_t  cmd
);
  import cbm_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.decode = 1'b1;
        state_nxt  = ST_SCAN;
      end
      ST_SCAN: begin
        priority if (st.none_left) begin
          state_nxt = ST_IDLE;
        end else if (!st.cur_valid) begin
          cmd.next_idx = 1'b1;
        end else if (st.need_mod) begin
          cmd.mod_start = 1'b1;
          state_nxt     = ST_MOD;
        end else begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_OUT;
        end
      end
      ST_MOD: begin
        if (!st.mod_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_tready) begin
          cmd.next_idx = 1'b1;
          state_nxt    = ST_SCAN;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);

  `CBM_ASSERT_NOW(a_no_overlap, in_tready, !out_tvalid, "input taken while result pending")
  `CBM_ASSERT_NEXT(a_mod_runs, cmd.mod_start, st.mod_busy, "remainder unit did not start")
  `CBM_ASSERT_NEXT(a_last_ends, out_tvalid && out_tready && out_last, !out_tvalid,
    "result after last")
endmodule

// ===== rtl/core/cartridge_bank_mapper_with_irq_unit.sv =====
// Cartridge bank mapper with scanline IRQ counter, top level.
// Flow: an accepted item passes ST_DECODE and ST_SCAN; a bank result then runs through
// the 11-step remainder unit (ST_MOD) before ST_OUT, other results go to ST_OUT directly.
// Items: one item at a time; a new item is accepted only after the last result
// of the current item has been handed out.
// Reset (rst_n, synchronous): registers to defaults, mapper state cleared, ready at once.
module cartridge_bank_mapper_with_irq_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // address[15:0], data[23:16]
  input  logic [2:0]  in_tuser,   // kind[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // slot[2:0], page[13:3], value[21:14], zero[23:22]
  output logic [2:0]  out_tuser,  // event_res[2:0]
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import cbm_pkg::*;

  cmd_t  cmd;
  stat_t st;
  logic [2:0]        o_slot;
  logic [PAGE_W-1:0] o_page;
  logic [7:0]        o_value;

  cbm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_last   (out_tlast),
    .st         (st),
    .cmd        (cmd)
  );

  cbm_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .in_kind    (in_tuser),
    .in_address (in_tdata[15:0]),
    .in_data    (in_tdata[23:16]),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .o_event    (out_tuser),
    .o_slot     (o_slot),
    .o_page     (o_page),
    .o_value    (o_value),
    .o_last     (out_tlast)
  );

  assign out_tdata = {2'b00, o_value, o_page, o_slot};
endmodule

// ===== test/cartridge_bank_mapper_with_irq_unit_tb.sv =====
// Self-checking bench for the cartridge bank mapper: drives bus events, predicts the
// bank, mirroring, read and IRQ items in a local model, and checks them in order.
// Depends on cbm_pkg and the cartridge_bank_mapper_with_irq_unit RTL.
module cartridge_bank_mapper_with_irq_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cbm_pkg::*;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] addr;
    logic [7:0]  data;
  } bus_ev_t;

  typedef struct packed {
    logic [2:0]  ev;
    logic [2:0]  slot;
    logic [10:0] page;
    logic [7:0]  value;
    logic        last;
  } map_upd_t;

  logic clk = 0, rst_n = 0;
  logic in_tvalid = 0, in_tready, out_tvalid, out_tready = 0, out_tlast;
  logic [23:0] in_tdata = '0, out_tdata;
  logic [2:0] in_tuser = '0, out_tuser;
  logic cfg_we = 0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  cartridge_bank_mapper_with_irq_unit u_dut (.*);

  bus_ev_t ev_q[$];
  map_upd_t upd_q[$];
  int send_idle = 0, recv_idle = 0, errors = 0;
  bit drv_en = 0;

  // mapper model state
  int unsigned prg_n = 16, chr_n = 256, step = 29104;
  logic [7:0] bsel, mode, expr;
  logic [9:0] cbase;
  logic [CNT_W-1:0] irq_cnt;
  logic irq_en;

  function automatic void push_upd(logic [2:0] e, int unsigned s, int unsigned p,
                                   int unsigned v);
    map_upd_t u;
    u.ev = e; u.slot = s[2:0]; u.page = p[10:0]; u.value = v[7:0]; u.last = 0;
    upd_q.push_back(u);
  endfunction

  function automatic void prg_upd(int unsigned s, int unsigned p);
    if (prg_n != 0) push_upd(EV_PRG, s, p % prg_n, 0);
  endfunction

  function automatic void chr_upd(int unsigned s, int unsigned p);
    if (chr_n != 0) push_upd(EV_CHR, s, p % chr_n, 0);
  endfunction

  function automatic void predict_map(bus_ev_t b);
    int n0;
    int unsigned d, e, x, s;
    logic [15:0] integ;
    n0 = upd_q.size();
    d = b.data;
    case (b.kind)
      KIND_START: begin
        bsel = 0; expr = 0; cbase = 0; irq_cnt = 0; irq_en = 0;
        prg_upd(0, 0); prg_upd(1, 1);
        if (prg_n >= 32) begin
          mode = 8'h30; prg_upd(2, 30); prg_upd(3, 31);
        end else begin
          mode = 0;
          prg_upd(2, prg_n >= 2 ? prg_n - 2 : 0);
          prg_upd(3, prg_n >= 1 ? prg_n - 1 : 0);
        end
        for (int k = 0; k < 8; k++) chr_upd(k, k);
      end
      KIND_WRITE: begin
        if (b.addr inside {A_BANK0, A_BANK1, A_BANK2, A_BANK3}) begin
          e = (d & 'h30) | 'h0F;
          bsel = d; cbase = (d & 'h30) << 4;
          prg_upd(0, d * 2); prg_upd(1, d * 2 + 1);
          prg_upd(2, e * 2); prg_upd(3, e * 2 + 1);
        end else if (b.addr == A_MODE) begin
          if (chr_n <= 256) mode = d;
          push_upd(EV_MIR, 0, 0, d & 3);
        end else if (b.addr == A_IRQ_LO || b.addr == A_IRQ_HI) begin
          integ = irq_cnt[CNT_W-1:FRAC_BITS];
          if (b.addr == A_IRQ_LO) integ[7:0] = b.data;
          else begin
            integ[15:8] = b.data; irq_en = (b.data != 0);
          end
          irq_cnt = {integ, {FRAC_BITS{1'b0}}};
        end else if (b.addr >= A_PRG0 && b.addr <= A_PRG2) begin
          prg_upd(b.addr - A_PRG0, d);
        end else if (b.addr >= A_CHR0 && b.addr <= A_CHR7) begin
          x = (cbase ^ d) & 'h3FF;
          if (mode[5:4] == 2'b11) chr_upd(b.addr[2:0], x);
          else if (mode[5:4] != 2'b00) begin
            s = (b.addr[2:0] == 0) ? 0 : (b.addr[2:0] == 1) ? 2 : b.addr[0] ? 6 : 4;
            chr_upd(s, x * 2); chr_upd(s + 1, x * 2 + 1);
          end
        end else if (b.addr == A_PRG_X) begin
          x = (bsel & 'h30) | d;
          prg_upd(0, x * 2); prg_upd(1, x * 2 + 1);
        end
      end
      KIND_EXPW: if (b.addr >= A_EXP_LO && b.addr <= A_EXP_HI) expr = b.data;
      KIND_EXPR: push_upd(EV_READ, 0, 0,
                          ((b.addr & A_EXP_M) == A_EXP_M) ? expr : b.addr[15:8]);
      KIND_TICK: if (irq_en) begin
        if (irq_cnt <= step) begin
          push_upd(EV_IRQ, 0, 0, 0); irq_en = 0;
        end else irq_cnt = irq_cnt - step;
      end
      default: ;
    endcase
    if (upd_q.size() > n0) upd_q[$].last = 1;
  endfunction

  // driver
  always @(posedge clk) begin
    if (in_tvalid && in_tready) predict_map(bus_ev_t'({in_tuser, in_tdata[15:0],
                                                       in_tdata[23:16]}));
    if (!in_tvalid || in_tready) begin
      if (drv_en && ev_q.size() > 0 && $urandom_range(99) >= send_idle) begin
        bus_ev_t b;
        b = ev_q.pop_front();
        in_tvalid <= 1; in_tuser <= b.kind; in_tdata <= {b.data, b.addr};
      end else in_tvalid <= 0;
    end
    out_tready <= ($urandom_range(99) >= recv_idle);
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      map_upd_t got, want;
      got = {out_tuser, out_tdata[2:0], out_tdata[13:3], out_tdata[21:14], out_tlast};
      if (upd_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected item %h", $time, got);
      end else begin
        want = upd_q.pop_front();
        if (got !== want || out_tdata[23:22] !== 2'b00) begin
          errors++;
          $display("%0t: mismatch expected %h actual %h", $time, want, got);
        end
      end
    end
  end

  task automatic add_ev(logic [2:0] k, logic [15:0] a, logic [7:0] d);
    ev_q.push_back('{k, a, d});
  endtask

  task automatic drain();
    while (ev_q.size() > 0 || in_tvalid || upd_q.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_reg(logic [1:0] i, int unsigned v);
    @(posedge clk);
    cfg_we <= 1; cfg_index <= i; cfg_wdata <= v[15:0];
    @(posedge clk);
    cfg_we <= 0;
    case (i)
      CFG_PRG_PAGES: prg_n = v & 'h1FF;
      CFG_CHR_PAGES: chr_n = v & 'h7FF;
      default:       step = v & 'hFFFF;
    endcase
  endtask

  function automatic logic [15:0] rand_addr();
    logic [15:0] t[15] = '{A_BANK0, A_BANK1, A_BANK2, A_BANK3, A_MODE, A_IRQ_LO,
                           A_IRQ_HI, A_PRG0, 16'h8301, A_PRG2, A_PRG_X, A_EXP_LO,
                           16'h5102, A_EXP_HI, A_EXP_M};
    case ($urandom_range(9))
      0, 1: return 16'($urandom_range(16'hFFFF));
      2, 3: return A_CHR0 + 16'($urandom_range(7));
      default: return t[$urandom_range(14)];
    endcase
  endfunction

  task automatic rand_phase(int n);
    for (int i = 0; i < n; i++) begin
      int r;
      r = $urandom_range(99);
      if (r < 3) add_ev(KIND_START, 16'($urandom), 8'($urandom));
      else if (r < 55) add_ev(KIND_WRITE, rand_addr(), 8'($urandom));
      else if (r < 65) add_ev(KIND_EXPW, rand_addr(), 8'($urandom));
      else if (r < 75) add_ev(KIND_EXPR, rand_addr(), 8'($urandom));
      else if (r < 97) add_ev(KIND_TICK, 16'($urandom), 8'($urandom));
      else add_ev(3'($urandom_range(7, 5)), 16'($urandom), 8'($urandom));
    end
    drain();
  endtask

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    bsel = 0; mode = 0; expr = 0; cbase = 0; irq_cnt = 0; irq_en = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    set_reg(CFG_PRG_PAGES, 2);
    set_reg(CFG_CHR_PAGES, 0);
    set_reg(CFG_STEP, 1);
    drv_en = 1;
    add_ev(KIND_START, 16'h0000, 8'h00);
    add_ev(KIND_WRITE, A_BANK0, 8'hFF);
    add_ev(KIND_WRITE, A_CHR0, 8'h12);
    add_ev(KIND_WRITE, A_IRQ_LO, 8'h02);
    add_ev(KIND_WRITE, A_IRQ_HI, 8'h00);
    add_ev(KIND_WRITE, A_IRQ_HI, 8'h01);
    add_ev(KIND_TICK, 16'hFFFF, 8'hFF);
    add_ev(KIND_EXPW, A_EXP_HI, 8'hA5);
    add_ev(KIND_EXPR, A_EXP_M, 8'h00);
    add_ev(KIND_EXPR, 16'hFFFF, 8'h00);
    add_ev(KIND_EXPR, 16'h0000, 8'h00);
    add_ev(3'd7, 16'hFFFF, 8'hFF);
    drain();
    set_reg(CFG_PRG_PAGES, 510);
    set_reg(CFG_CHR_PAGES, 2040);
    set_reg(CFG_STEP, 65535);
    add_ev(KIND_START, 16'h0000, 8'h00);
    add_ev(KIND_WRITE, A_CHR7, 8'hFF);
    add_ev(KIND_WRITE, A_PRG_X, 8'hFF);
    add_ev(KIND_WRITE, A_IRQ_HI, 8'hFF);
    add_ev(KIND_TICK, 16'h0000, 8'h00);
    add_ev(KIND_WRITE, A_MODE, 8'h13);
    drain();
    set_reg(CFG_CHR_PAGES, 256);
    set_reg(CFG_STEP, 29104);
    add_ev(KIND_WRITE, A_MODE, 8'h10);
    add_ev(KIND_WRITE, A_CHR0 + 16'd5, 8'h03);
    drain();
    send_idle = 35; recv_idle = 88;
    set_reg(CFG_PRG_PAGES, 1 + $urandom_range(40));
    set_reg(CFG_STEP, 256 + $urandom_range(4000));
    rand_phase(120);
    send_idle = 88; recv_idle = 35;
    set_reg(CFG_CHR_PAGES, $urandom_range(300));
    rand_phase(110);
    send_idle = 0; recv_idle = 0;
    set_reg(CFG_PRG_PAGES, $urandom_range(510, 2));
    set_reg(CFG_CHR_PAGES, $urandom_range(2040, 1));
    set_reg(CFG_STEP, $urandom_range(65535, 1));
    rand_phase(120);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule

// ===== cartridge_bank_mapper_with_irq_unit.f =====
+incdir+rtl/core
rtl/core/cbm_pkg.sv
rtl/core/cbm_mod.sv
rtl/core/cbm_dp.sv
rtl/core/cbm_ctrl.sv
rtl/core/cartridge_bank_mapper_with_irq_unit.sv
test/cartridge_bank_mapper_with_irq_unit_tb.sv
